/* src/lac_pkg.sv */
// Shared types, constants and tables of the line activity classifier.
package lac_pkg;

	localparam int MAX_RUNS   = 256;
	localparam int MAX_WINDOW = 512;

	localparam int WIN_W  = 10;
	localparam int PER_W  = 14;
	localparam int CNT_W  = 9;
	localparam int IDX_W  = $clog2(MAX_WINDOW + 1);
	localparam int RUN_W  = IDX_W;
	localparam int RUNS_W = $clog2(MAX_RUNS + 1);

	localparam int MUL_A_W    = (RUN_W > WIN_W) ? RUN_W : WIN_W;
	localparam int DEN_W      = MUL_A_W + PER_W;
	localparam int NUM_W      = 32;
	localparam int DIV_STEPS  = NUM_W;
	localparam int DIV_CNT_W  = $clog2(DIV_STEPS);

	localparam int US_W   = 23;
	localparam int RAW_W  = 18;
	localparam int SNAP_W = 17;
	localparam int FREQ_W = 23;
	localparam int SPI_W  = WIN_W + 2;

	localparam int N_BAUDS    = 8;
	localparam int BAUD_IDX_W = $clog2(N_BAUDS);

	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = PER_W;
	localparam logic [CFG_IDX_W-1:0] CFG_WINDOW = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_PERIOD = 1'b1;

	localparam logic [WIN_W-1:0] WIN_DEFAULT = WIN_W'(256);
	localparam logic [WIN_W-1:0] WIN_LOW     = WIN_W'(16);
	localparam logic [PER_W-1:0] PER_DEFAULT = PER_W'(5);
	localparam logic [PER_W-1:0] PER_LOW     = PER_W'(1);
	localparam logic [PER_W-1:0] PER_HIGH    = PER_W'(10000);

	localparam logic [NUM_W-1:0] BAUD_NUM   = NUM_W'(1000000);
	localparam logic [DEN_W-1:0] FREQ_SCALE = DEN_W'(5000000);

	localparam logic [DEN_W-1:0] RAW_MIN_US   = DEN_W'(5);
	localparam logic [DEN_W-1:0] I2C_MIN_US   = DEN_W'(10);
	localparam logic [DEN_W-1:0] I2C_MAX_US   = DEN_W'(500);
	localparam logic [DEN_W-1:0] SPI_MAX_US   = DEN_W'(50);
	localparam logic [DEN_W-1:0] PWM_MIN_US   = DEN_W'(500);
	localparam logic [DEN_W-1:0] SERVO_MAX_US = DEN_W'(2500);
	localparam logic [CNT_W-1:0] SPI_EDGES    = CNT_W'(20);
	localparam logic [CNT_W-1:0] PWM_EDGES    = CNT_W'(10);
	localparam logic [CNT_W-1:0] FREQ_EDGES   = CNT_W'(2);

	typedef enum logic [1:0] {
		PWM_NONE    = 2'd0,
		PWM_SERVO   = 2'd1,
		PWM_GENERIC = 2'd2
	} pwm_t;

	typedef enum logic {
		OP_MUL = 1'b0,
		OP_DIV = 1'b1
	} arith_op_t;

	typedef struct packed {
		logic      start;
		arith_op_t op;
	} arith_cmd_t;

	typedef struct packed {
		logic busy;
		logic done;
	} arith_sts_t;

	typedef struct packed {
		logic             first_level;
		logic [CNT_W-1:0] edges;
		logic [CNT_W-1:0] highs;
		logic [RUN_W-1:0] shortest;
		logic [RUN_W-1:0] longest;
	} stats_t;

	typedef struct packed {
		logic              first_level;
		logic [CNT_W-1:0]  edge_count;
		logic [CNT_W-1:0]  high_count;
		logic [US_W-1:0]   min_pulse_us;
		logic [US_W-1:0]   max_pulse_us;
		logic              uart_likely;
		logic [RAW_W-1:0]  raw_baud;
		logic [SNAP_W-1:0] snapped_baud;
		logic              i2c_possible;
		logic              spi_clock_possible;
		pwm_t              pwm_class;
		logic [FREQ_W-1:0] freq_tenth_hz;
	} report_t;

	function automatic logic [SNAP_W-1:0] baud_at(input logic [BAUD_IDX_W-1:0] idx);
		logic [SNAP_W-1:0] b;
		unique case (idx)
			3'd0: b = SNAP_W'(9600);
			3'd1: b = SNAP_W'(19200);
			3'd2: b = SNAP_W'(38400);
			3'd3: b = SNAP_W'(57600);
			3'd4: b = SNAP_W'(115200);
			3'd5: b = SNAP_W'(4800);
			3'd6: b = SNAP_W'(2400);
			default: b = SNAP_W'(1200);
		endcase
		return b;
	endfunction

endpackage

/* src/line_activity_classifier_top.sv */
// Top level of the line activity classifier.
//
//  channel   dir  handshake                 payload
//  s_axis    in   s_axis_tvalid/tready      tdata[0] line_level
//  m_axis    out  m_axis_tvalid/tready      tdata[127:0] one report per window
//  config    in   wr_en                     wr_index, wr_data
//
// Each sample takes one cycle. The sample that closes a window starts the
// report: s_axis_tready stays low through four multiplies and two 32-step
// serial divisions in the shared unit plus eight baud-table steps; skipped
// divisions shorten it. The finished report sits in an output register, so
// sampling resumes while a stalled m_axis request waits. Reset loads the
// default window and period and clears all window statistics.
module line_activity_classifier_top (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_axis_tvalid,
	output logic                           s_axis_tready,
	// [0] line_level, [7:1] zero
	input  logic [7:0]                     s_axis_tdata,
	output logic                           m_axis_tvalid,
	input  logic                           m_axis_tready,
	// [0] first_level, [9:1] edge_count, [18:10] high_count,
	// [41:19] min_pulse_us, [64:42] max_pulse_us, [65] uart_likely,
	// [83:66] raw_baud, [100:84] snapped_baud, [101] i2c_possible,
	// [102] spi_clock_possible, [104:103] pwm_class, [127:105] freq_tenth_hz
	output logic [127:0]                   m_axis_tdata,
	input  logic                           wr_en,
	input  logic [lac_pkg::CFG_IDX_W-1:0]  wr_index,
	input  logic [lac_pkg::CFG_DATA_W-1:0] wr_data
);
	import lac_pkg::*;

	logic [WIN_W-1:0] window_q;
	logic [PER_W-1:0] period_q;
	logic             out_valid_q;
	report_t          out_q;

	logic [WIN_W-1:0] win_wr;
	logic [PER_W-1:0] per_wr;
	logic             sample_accept;
	logic             window_end;
	logic             idle;
	logic             finish;
	logic             clear;
	logic             report_valid;
	logic             report_take;
	stats_t           stats;
	report_t          report;
	arith_cmd_t       cmd;
	arith_sts_t       asts;
	logic [NUM_W-1:0] opa;
	logic [DEN_W-1:0] opb;
	logic [NUM_W-1:0] res;

	assign win_wr = wr_data[WIN_W-1:0];
	assign per_wr = wr_data[PER_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_q <= WIN_DEFAULT;
			period_q <= PER_DEFAULT;
		end else if (wr_en) begin
			unique case (wr_index)
				CFG_WINDOW: begin
					window_q <= ((win_wr < WIN_LOW) || (32'(win_wr) > 32'(MAX_WINDOW)))
						? WIN_DEFAULT : win_wr;
				end
				CFG_PERIOD: begin
					period_q <= ((per_wr < PER_LOW) || (per_wr > PER_HIGH))
						? PER_DEFAULT : per_wr;
				end
			endcase
		end
	end

	assign s_axis_tready = idle;
	assign sample_accept = s_axis_tvalid && s_axis_tready;

	lac_stats u_stats (
		.clk           (clk),
		.arst_n        (arst_n),
		.sample_accept (sample_accept),
		.level         (s_axis_tdata[0]),
		.window        (window_q),
		.finish        (finish),
		.clear         (clear),
		.window_end    (window_end),
		.stats         (stats)
	);

	lac_arith u_arith (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.opa    (opa),
		.opb    (opb),
		.res    (res),
		.sts    (asts)
	);

	lac_seq u_seq (
		.clk          (clk),
		.arst_n       (arst_n),
		.window_end   (window_end),
		.stats        (stats),
		.window       (window_q),
		.period       (period_q),
		.idle         (idle),
		.finish       (finish),
		.clear        (clear),
		.cmd          (cmd),
		.opa          (opa),
		.opb          (opb),
		.res          (res),
		.asts         (asts),
		.report       (report),
		.report_valid (report_valid),
		.report_take  (report_take)
	);

	assign report_take = report_valid && (!out_valid_q || m_axis_tready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (report_take) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (report_take) begin
			out_q <= report;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {
		out_q.freq_tenth_hz,
		out_q.pwm_class,
		out_q.spi_clock_possible,
		out_q.i2c_possible,
		out_q.snapped_baud,
		out_q.raw_baud,
		out_q.uart_likely,
		out_q.max_pulse_us,
		out_q.min_pulse_us,
		out_q.high_count,
		out_q.edge_count,
		out_q.first_level
	};

endmodule

/* src/lac_stats.sv */
// Per-sample window statistics: edges, high samples and run lengths.
module lac_stats (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       sample_accept,
	input  logic                       level,
	input  logic [lac_pkg::WIN_W-1:0]  window,
	input  logic                       finish,
	input  logic                       clear,
	output logic                       window_end,
	output lac_pkg::stats_t            stats
);
	import lac_pkg::*;

	localparam int CMP_W = (IDX_W > WIN_W) ? IDX_W : WIN_W;

	logic             prior_q;
	logic             first_q;
	logic [IDX_W-1:0] idx_q;
	logic [RUN_W-1:0] run_q;
	logic [CNT_W-1:0] edges_q;
	logic [CNT_W-1:0] highs_q;
	logic [RUNS_W-1:0] runs_q;
	logic [RUN_W-1:0] shortest_q;
	logic [RUN_W-1:0] longest_q;

	logic [IDX_W-1:0] idx_next;
	logic             edge_ev;
	logic             note_en;

	assign idx_next   = idx_q + 1'b1;
	assign window_end = sample_accept && (CMP_W'(idx_next) >= CMP_W'(window));
	assign edge_ev    = sample_accept && (idx_q != '0) && (level != prior_q);
	assign note_en    = (edge_ev || finish) && (runs_q < RUNS_W'(MAX_RUNS));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prior_q    <= 1'b0;
			first_q    <= 1'b0;
			idx_q      <= '0;
			run_q      <= RUN_W'(1);
			edges_q    <= '0;
			highs_q    <= '0;
			runs_q     <= '0;
			shortest_q <= '1;
			longest_q  <= '0;
		end else if (clear) begin
			prior_q    <= 1'b0;
			first_q    <= 1'b0;
			idx_q      <= '0;
			run_q      <= RUN_W'(1);
			edges_q    <= '0;
			highs_q    <= '0;
			runs_q     <= '0;
			shortest_q <= '1;
			longest_q  <= '0;
		end else begin
			if (sample_accept) begin
				idx_q <= idx_next;
				if (idx_q == '0) begin
					first_q <= level;
					prior_q <= level;
					run_q   <= RUN_W'(1);
				end else begin
					if (edge_ev) begin
						edges_q <= edges_q + 1'b1;
						run_q   <= RUN_W'(1);
						prior_q <= level;
					end else begin
						run_q <= run_q + 1'b1;
					end
					if (level) begin
						highs_q <= highs_q + 1'b1;
					end
				end
			end
			if (note_en) begin
				runs_q <= runs_q + 1'b1;
				if (run_q < shortest_q) begin
					shortest_q <= run_q;
				end
				if (run_q > longest_q) begin
					longest_q <= run_q;
				end
			end
		end
	end

	assign stats.first_level = first_q;
	assign stats.edges       = edges_q;
	assign stats.highs       = highs_q;
	assign stats.shortest    = shortest_q;
	assign stats.longest     = longest_q;

endmodule

/* src/lac_arith.sv */
// Shared arithmetic unit: registered multiply and bit-serial restoring divide.
module lac_arith (
	input  logic                       clk,
	input  logic                       arst_n,
	input  lac_pkg::arith_cmd_t        cmd,
	input  logic [lac_pkg::NUM_W-1:0]  opa,
	input  logic [lac_pkg::DEN_W-1:0]  opb,
	output logic [lac_pkg::NUM_W-1:0]  res,
	output lac_pkg::arith_sts_t        sts
);
	import lac_pkg::*;

	logic [NUM_W-1:0]         res_q;
	logic [DEN_W-1:0]         rem_q;
	logic [DEN_W-1:0]         den_q;
	logic [DIV_CNT_W-1:0]     cnt_q;
	logic                     busy_q;
	logic                     done_q;

	logic [MUL_A_W+DEN_W-1:0] prod;
	logic [DEN_W:0]           shifted;
	logic                     ge;

	assign prod    = opa[MUL_A_W-1:0] * opb;
	assign shifted = {rem_q, res_q[NUM_W-1]};
	assign ge      = shifted >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_q  <= '0;
			rem_q  <= '0;
			den_q  <= '0;
			cnt_q  <= '0;
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (busy_q) begin
				rem_q <= ge ? DEN_W'(shifted - {1'b0, den_q}) : shifted[DEN_W-1:0];
				res_q <= {res_q[NUM_W-2:0], ge};
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == DIV_CNT_W'(DIV_STEPS - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end else if (cmd.start) begin
				unique case (cmd.op)
					OP_MUL: begin
						res_q  <= NUM_W'(prod);
						done_q <= 1'b1;
					end
					OP_DIV: begin
						res_q  <= opa;
						rem_q  <= '0;
						den_q  <= opb;
						cnt_q  <= '0;
						busy_q <= 1'b1;
					end
				endcase
			end
		end
	end

	assign res      = res_q;
	assign sts.busy = busy_q;
	assign sts.done = done_q;

endmodule

/* src/lac_seq.sv */
// Report sequencer: drives the shared unit, snaps the baud rate and sets the flags.
module lac_seq (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       window_end,
	input  lac_pkg::stats_t            stats,
	input  logic [lac_pkg::WIN_W-1:0]  window,
	input  logic [lac_pkg::PER_W-1:0]  period,
	output logic                       idle,
	output logic                       finish,
	output logic                       clear,
	output lac_pkg::arith_cmd_t        cmd,
	output logic [lac_pkg::NUM_W-1:0]  opa,
	output logic [lac_pkg::DEN_W-1:0]  opb,
	input  logic [lac_pkg::NUM_W-1:0]  res,
	input  lac_pkg::arith_sts_t        asts,
	output lac_pkg::report_t           report,
	output logic                       report_valid,
	input  logic                       report_take
);
	import lac_pkg::*;

	typedef enum logic [10:0] {
		ST_IDLE  = 11'b00000000001,
		ST_FIN   = 11'b00000000010,
		ST_MIN   = 11'b00000000100,
		ST_MAX   = 11'b00000001000,
		ST_NPER  = 11'b00000010000,
		ST_EPROD = 11'b00000100000,
		ST_RAW   = 11'b00001000000,
		ST_SNAP  = 11'b00010000000,
		ST_FREQ  = 11'b00100000000,
		ST_FLAGS = 11'b01000000000,
		ST_OUT   = 11'b10000000000
	} seq_state_t;

	seq_state_t              state_q;
	logic                    issued_q;
	logic [DEN_W-1:0]        min_us_q;
	logic [DEN_W-1:0]        max_us_q;
	logic [DEN_W-1:0]        nper_q;
	logic [NUM_W-1:0]        num_q;
	logic [RAW_W-1:0]        raw_q;
	logic [SNAP_W-1:0]       snap_q;
	logic [RAW_W-1:0]        best_q;
	logic [BAUD_IDX_W-1:0]   idx_q;
	logic [NUM_W-1:0]        freq_q;
	report_t                 report_q;

	logic                    want;
	logic                    has_edges;
	logic                    raw_ok;
	logic                    freq_ok;
	logic [RAW_W-1:0]        baud_x;
	logic [RAW_W-1:0]        err;
	logic [RAW_W+3:0]        ten_best;
	logic [SPI_W-1:0]        h5;
	logic [SPI_W-1:0]        n2;
	logic [SPI_W-1:0]        n3;
	logic                    spi;
	pwm_t                    pwm;

	assign has_edges = stats.edges != '0;
	assign raw_ok    = has_edges && (min_us_q >= RAW_MIN_US);
	assign freq_ok   = stats.edges >= FREQ_EDGES;

	assign baud_x   = RAW_W'(baud_at(idx_q));
	assign err      = (raw_q > baud_x) ? raw_q - baud_x : baud_x - raw_q;
	assign ten_best = (RAW_W+4)'({best_q, 3'b000}) + (RAW_W+4)'({best_q, 1'b0});

	assign h5 = SPI_W'({stats.highs, 2'b00}) + SPI_W'(stats.highs);
	assign n2 = SPI_W'({window, 1'b0});
	assign n3 = n2 + SPI_W'(window);
	assign spi = has_edges && (stats.edges > SPI_EDGES) && (h5 > n2) && (h5 < n3)
		&& (min_us_q < SPI_MAX_US);

	always_comb begin
		pwm = PWM_NONE;
		if (has_edges && (stats.edges < PWM_EDGES) && (min_us_q > PWM_MIN_US)) begin
			pwm = (max_us_q <= SERVO_MAX_US) ? PWM_SERVO : PWM_GENERIC;
		end
	end

	always_comb begin
		want   = 1'b0;
		cmd.op = OP_MUL;
		opa    = '0;
		opb    = '0;
		unique case (state_q)
			ST_MIN: begin
				want = 1'b1;
				opa  = NUM_W'(stats.shortest);
				opb  = DEN_W'(period);
			end
			ST_MAX: begin
				want = 1'b1;
				opa  = NUM_W'(stats.longest);
				opb  = DEN_W'(period);
			end
			ST_NPER: begin
				want = 1'b1;
				opa  = NUM_W'(window);
				opb  = DEN_W'(period);
			end
			ST_EPROD: begin
				want = 1'b1;
				opa  = NUM_W'(stats.edges);
				opb  = FREQ_SCALE;
			end
			ST_RAW: begin
				want   = raw_ok;
				cmd.op = OP_DIV;
				opa    = BAUD_NUM;
				opb    = min_us_q;
			end
			ST_FREQ: begin
				want   = freq_ok;
				cmd.op = OP_DIV;
				opa    = num_q;
				opb    = nper_q;
			end
			default: begin
			end
		endcase
		cmd.start = want && !issued_q && !asts.busy;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			issued_q <= 1'b0;
			min_us_q <= '0;
			max_us_q <= '0;
			nper_q   <= '0;
			num_q    <= '0;
			raw_q    <= '0;
			snap_q   <= '0;
			best_q   <= '1;
			idx_q    <= '0;
			freq_q   <= '0;
			report_q <= '0;
		end else begin
			if (cmd.start) begin
				issued_q <= 1'b1;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (window_end) begin
						state_q <= ST_FIN;
					end
				end
				ST_FIN: begin
					issued_q <= 1'b0;
					raw_q    <= '0;
					snap_q   <= '0;
					best_q   <= '1;
					idx_q    <= '0;
					freq_q   <= '0;
					state_q  <= ST_MIN;
				end
				ST_MIN: begin
					if (asts.done) begin
						issued_q <= 1'b0;
						min_us_q <= DEN_W'(res);
						state_q  <= ST_MAX;
					end
				end
				ST_MAX: begin
					if (asts.done) begin
						issued_q <= 1'b0;
						max_us_q <= DEN_W'(res);
						state_q  <= ST_NPER;
					end
				end
				ST_NPER: begin
					if (asts.done) begin
						issued_q <= 1'b0;
						nper_q   <= DEN_W'(res);
						state_q  <= ST_EPROD;
					end
				end
				ST_EPROD: begin
					if (asts.done) begin
						issued_q <= 1'b0;
						num_q    <= res;
						state_q  <= ST_RAW;
					end
				end
				ST_RAW: begin
					if (!raw_ok) begin
						state_q <= ST_FREQ;
					end else if (asts.done) begin
						issued_q <= 1'b0;
						raw_q    <= res[RAW_W-1:0];
						state_q  <= ST_SNAP;
					end
				end
				ST_SNAP: begin
					if (err < best_q) begin
						best_q <= err;
						snap_q <= baud_at(idx_q);
					end
					idx_q <= idx_q + 1'b1;
					if (idx_q == BAUD_IDX_W'(N_BAUDS - 1)) begin
						state_q <= ST_FREQ;
					end
				end
				ST_FREQ: begin
					if (!freq_ok) begin
						state_q <= ST_FLAGS;
					end else if (asts.done) begin
						issued_q <= 1'b0;
						freq_q   <= res;
						state_q  <= ST_FLAGS;
					end
				end
				ST_FLAGS: begin
					report_q.first_level        <= stats.first_level;
					report_q.edge_count         <= stats.edges;
					report_q.high_count         <= stats.highs;
					report_q.min_pulse_us       <= min_us_q[US_W-1:0];
					report_q.max_pulse_us       <= max_us_q[US_W-1:0];
					report_q.uart_likely        <= ten_best < (RAW_W+4)'(snap_q);
					report_q.raw_baud           <= raw_q;
					report_q.snapped_baud       <= snap_q;
					report_q.i2c_possible       <= has_edges && (min_us_q <= I2C_MIN_US)
						&& (max_us_q >= I2C_MAX_US);
					report_q.spi_clock_possible <= spi;
					report_q.pwm_class          <= pwm;
					report_q.freq_tenth_hz      <= freq_q[FREQ_W-1:0];
					state_q                     <= ST_OUT;
				end
				ST_OUT: begin
					if (report_take) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign idle         = state_q == ST_IDLE;
	assign finish       = state_q == ST_FIN;
	assign report_valid = state_q == ST_OUT;
	assign clear        = report_valid && report_take;
	assign report       = report_q;

endmodule

/* src/lac_checker.sv */
// Port-level checks of the line activity classifier and their binding.
module lac_checker (
	input logic         clk,
	input logic         arst_n,
	input logic         m_axis_tvalid,
	input logic         m_axis_tready,
	input logic [127:0] m_axis_tdata
);
	import lac_pkg::*;

	logic [CNT_W-1:0]  edge_count;
	logic              uart_likely;
	logic [RAW_W-1:0]  raw_baud;
	logic [SNAP_W-1:0] snapped_baud;
	logic              i2c_possible;
	logic              spi_clock_possible;
	logic [1:0]        pwm_class;
	logic [FREQ_W-1:0] freq_tenth_hz;

	assign edge_count         = m_axis_tdata[9:1];
	assign uart_likely        = m_axis_tdata[65];
	assign raw_baud           = m_axis_tdata[83:66];
	assign snapped_baud       = m_axis_tdata[100:84];
	assign i2c_possible       = m_axis_tdata[101];
	assign spi_clock_possible = m_axis_tdata[102];
	assign pwm_class          = m_axis_tdata[104:103];
	assign freq_tenth_hz      = m_axis_tdata[127:105];

	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("report changed while stalled");

	a_quiet_line: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && (edge_count == '0) |-> !uart_likely && (raw_baud == '0)
			&& (snapped_baud == '0) && !i2c_possible && !spi_clock_possible
			&& (pwm_class == PWM_NONE) && (freq_tenth_hz == '0))
		else $error("flags set on a line without edges");

	a_uart_snap: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && uart_likely |-> snapped_baud != '0)
		else $error("uart flagged without a snapped baud rate");

	a_freq_edges: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && (freq_tenth_hz != '0) |-> edge_count >= FREQ_EDGES)
		else $error("frequency reported with fewer than two edges");

	a_servo_edges: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && (pwm_class == PWM_SERVO) |-> (edge_count != '0)
			&& (edge_count < PWM_EDGES))
		else $error("servo class with an edge count out of range");

endmodule

bind line_activity_classifier_top lac_checker u_lac_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata)
);

/* tb/sv/line_activity_classifier_top_tb.sv */
// Testbench for the line activity classifier: table-driven and random sample streams, reports checked against a predictor.
`timescale 1ns / 100ps

module line_activity_classifier_top_tb;
	import lac_pkg::*;

	localparam int SETTLE_CYCLES = 120;
	localparam int QUIET_LIMIT   = 4000;
	localparam int PLAN_ROWS     = 15;

	typedef enum logic [2:0] {
		PAT_CONST,
		PAT_SQUARE,
		PAT_NOISE,
		PAT_TAIL,
		PAT_RUNS
	} pat_t;

	typedef struct {
		bit   wr;
		int   win;
		int   per;
		pat_t pat;
		int   a;
		int   b;
		int   count;
		bit   typed;
		bit   wfirst;
		int   whighs;
		int   wus;
	} plan_row_t;

	logic                  clk           = 1'b0;
	logic                  arst_n        = 1'b0;
	logic                  s_axis_tvalid = 1'b0;
	logic                  s_axis_tready;
	logic [7:0]            s_axis_tdata  = '0;
	logic                  m_axis_tvalid;
	logic                  m_axis_tready = 1'b0;
	logic [127:0]          m_axis_tdata;
	logic                  wr_en         = 1'b0;
	logic [CFG_IDX_W-1:0]  wr_index      = CFG_WINDOW;
	logic [CFG_DATA_W-1:0] wr_data       = '0;

	// predictor copy of the window statistics and registers
	logic [WIN_W-1:0]  cfg_window;
	logic [PER_W-1:0]  cfg_period;
	logic              lvl_prev;
	logic              lvl_first;
	logic [IDX_W-1:0]  taken;
	logic [RUN_W-1:0]  run_len;
	logic [RUN_W-1:0]  run_min;
	logic [RUN_W-1:0]  run_max;
	logic [CNT_W-1:0]  edges_n;
	logic [CNT_W-1:0]  highs_n;
	logic [RUNS_W-1:0] runs_n;
	int unsigned       std_rate [8];

	report_t     reports_due [$];
	report_t     typed_report;
	logic        typed_pending = 1'b0;
	int          reports_seen  = 0;
	int          mismatches    = 0;
	int          quiet_cycles  = 0;
	logic        tx_hold       = 1'b0;
	logic        tx_quiet      = 1'b0;
	plan_row_t   plan [PLAN_ROWS];

	pat_t gen_pat;
	int   gen_a;
	int   gen_b;
	logic gen_inv;
	logic gen_lvl;
	int   gen_left;
	int   gen_cnt;

	line_activity_classifier_top i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.wr_en         (wr_en),
		.wr_index      (wr_index),
		.wr_data       (wr_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	task automatic clear_window();
		lvl_prev  = 1'b0;
		lvl_first = 1'b0;
		taken     = '0;
		run_len   = RUN_W'(1);
		edges_n   = '0;
		highs_n   = '0;
		runs_n    = '0;
		run_min   = '1;
		run_max   = '0;
	endtask

	task automatic log_run(input logic [RUN_W-1:0] len);
		if (runs_n < MAX_RUNS) begin
			runs_n++;
			if (len < run_min) run_min = len;
			if (len > run_max) run_max = len;
		end
	endtask

	task automatic take_sample(input logic lvl);
		report_t         r;
		longint unsigned lo_us;
		longint unsigned hi_us;
		longint unsigned raw;
		longint unsigned best;
		longint unsigned err;
		longint unsigned snap;
		if (taken == 0) begin
			lvl_first = lvl;
			lvl_prev  = lvl;
			run_len   = RUN_W'(1);
		end else begin
			if (lvl == lvl_prev) begin
				run_len++;
			end else begin
				edges_n++;
				log_run(run_len);
				run_len  = RUN_W'(1);
				lvl_prev = lvl;
			end
			if (lvl) highs_n++;
		end
		taken++;
		if (taken < cfg_window) return;

		log_run(run_len);
		lo_us = 64'(run_min) * 64'(cfg_period);
		hi_us = 64'(run_max) * 64'(cfg_period);
		r = '0;
		r.first_level  = lvl_first;
		r.edge_count   = edges_n;
		r.high_count   = highs_n;
		r.min_pulse_us = US_W'(lo_us);
		r.max_pulse_us = US_W'(hi_us);
		if (edges_n != 0) begin
			if (lo_us >= 5) begin
				best = 64'hFFFF_FFFF;
				snap = 0;
				raw  = 1000000 / lo_us;
				for (int i = 0; i < 8; i++) begin
					err = (raw > std_rate[i]) ? raw - std_rate[i] : std_rate[i] - raw;
					if (err < best) begin
						best = err;
						snap = std_rate[i];
					end
				end
				r.uart_likely  = (best * 10 < snap);
				r.raw_baud     = RAW_W'(raw);
				r.snapped_baud = SNAP_W'(snap);
			end
			r.i2c_possible = (lo_us <= 10 && hi_us >= 500);
			r.spi_clock_possible = (edges_n > 20 &&
				5 * 32'(highs_n) > 2 * 32'(cfg_window) &&
				5 * 32'(highs_n) < 3 * 32'(cfg_window) && lo_us < 50);
			if (edges_n < 10 && lo_us > 500)
				r.pwm_class = (hi_us <= 2500) ? PWM_SERVO : PWM_GENERIC;
			if (edges_n >= 2)
				r.freq_tenth_hz = FREQ_W'(64'(edges_n) * 5000000 /
					(64'(cfg_window) * 64'(cfg_period)));
		end
		if (typed_pending) begin
			reports_due.push_back(typed_report);
			typed_pending = 1'b0;
		end else begin
			reports_due.push_back(r);
		end
		clear_window();
	endtask

	task automatic write_regs(input logic do_win, input logic [CFG_DATA_W-1:0] win,
			input logic do_per, input logic [CFG_DATA_W-1:0] per);
		if (do_win) begin
			wr_en    <= 1'b1;
			wr_index <= CFG_WINDOW;
			wr_data  <= win;
			@(posedge clk);
			cfg_window = (win[WIN_W-1:0] < WIN_LOW || win[WIN_W-1:0] > MAX_WINDOW) ?
				WIN_DEFAULT : win[WIN_W-1:0];
		end
		if (do_per) begin
			wr_en    <= 1'b1;
			wr_index <= CFG_PERIOD;
			wr_data  <= per;
			@(posedge clk);
			cfg_period = (per < PER_LOW || per > PER_HIGH) ? PER_DEFAULT : per;
		end
		if (do_win || do_per) wr_en <= 1'b0;
	endtask

	task automatic settle();
		while (reports_due.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic gen_start(input pat_t pat, input int a, input int b, input logic inv);
		gen_pat  = pat;
		gen_a    = a;
		gen_b    = b;
		gen_inv  = inv;
		gen_lvl  = 1'b1;
		gen_cnt  = 0;
		gen_left = (pat == PAT_RUNS) ? $urandom_range(1, a) : a;
	endtask

	task automatic next_level(output logic lvl);
		lvl = gen_lvl;
		case (gen_pat)
			PAT_CONST: lvl = gen_a[0];
			PAT_NOISE: lvl = 1'($urandom_range(0, 1));
			PAT_TAIL: if (gen_cnt < gen_a) gen_lvl = !gen_lvl;
			default: begin
				gen_left--;
				if (gen_left <= 0) begin
					gen_lvl = !gen_lvl;
					if (gen_pat == PAT_RUNS) gen_left = $urandom_range(1, gen_a);
					else gen_left = gen_lvl ? gen_a : gen_b;
				end
			end
		endcase
		gen_cnt++;
		lvl = lvl ^ gen_inv;
	endtask

	task automatic send_level(input logic lvl);
		int gap;
		int r;
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= {7'b0, lvl};
		tx_hold = 1'b1;
		do @(posedge clk); while (!s_axis_tready);
		take_sample(lvl);
		gap = 0;
		if (!tx_quiet) begin
			r = $urandom_range(0, 99);
			if (r >= 97) gap = $urandom_range(8, 40);
			else if (r >= 75) gap = $urandom_range(1, 3);
		end
		if (gap != 0) begin
			s_axis_tvalid <= 1'b0;
			tx_hold = 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic stop_tx();
		if (tx_hold) begin
			s_axis_tvalid <= 1'b0;
			tx_hold = 1'b0;
		end
	endtask

	task automatic note_mismatch(input string field, input longint unsigned got,
			input longint unsigned want);
		mismatches++;
		$display("mismatch on %s at report %0d: got %0d, want %0d",
			field, reports_seen, got, want);
	endtask

	task automatic check_report(input report_t got, input report_t want);
		if (got.first_level !== want.first_level)
			note_mismatch("first_level", got.first_level, want.first_level);
		if (got.edge_count !== want.edge_count)
			note_mismatch("edge_count", got.edge_count, want.edge_count);
		if (got.high_count !== want.high_count)
			note_mismatch("high_count", got.high_count, want.high_count);
		if (got.min_pulse_us !== want.min_pulse_us)
			note_mismatch("min_pulse_us", got.min_pulse_us, want.min_pulse_us);
		if (got.max_pulse_us !== want.max_pulse_us)
			note_mismatch("max_pulse_us", got.max_pulse_us, want.max_pulse_us);
		if (got.uart_likely !== want.uart_likely)
			note_mismatch("uart_likely", got.uart_likely, want.uart_likely);
		if (got.raw_baud !== want.raw_baud)
			note_mismatch("raw_baud", got.raw_baud, want.raw_baud);
		if (got.snapped_baud !== want.snapped_baud)
			note_mismatch("snapped_baud", got.snapped_baud, want.snapped_baud);
		if (got.i2c_possible !== want.i2c_possible)
			note_mismatch("i2c_possible", got.i2c_possible, want.i2c_possible);
		if (got.spi_clock_possible !== want.spi_clock_possible)
			note_mismatch("spi_clock_possible", got.spi_clock_possible,
				want.spi_clock_possible);
		if (got.pwm_class !== want.pwm_class)
			note_mismatch("pwm_class", got.pwm_class, want.pwm_class);
		if (got.freq_tenth_hz !== want.freq_tenth_hz)
			note_mismatch("freq_tenth_hz", got.freq_tenth_hz, want.freq_tenth_hz);
	endtask

	function automatic report_t unpack_report(input logic [127:0] d);
		report_t r;
		r.first_level        = d[0];
		r.edge_count         = d[9:1];
		r.high_count         = d[18:10];
		r.min_pulse_us       = d[41:19];
		r.max_pulse_us       = d[64:42];
		r.uart_likely        = d[65];
		r.raw_baud           = d[83:66];
		r.snapped_baud       = d[100:84];
		r.i2c_possible       = d[101];
		r.spi_clock_possible = d[102];
		r.pwm_class          = pwm_t'(d[104:103]);
		r.freq_tenth_hz      = d[127:105];
		return r;
	endfunction

	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			reports_seen++;
			if (reports_due.size() == 0) note_mismatch("report with none pending", 1, 0);
			else check_report(unpack_report(m_axis_tdata), reports_due.pop_front());
		end
	end

	always @(posedge clk) begin
		if (!arst_n || wr_en || (s_axis_tvalid && s_axis_tready) ||
				(m_axis_tvalid && m_axis_tready)) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
		if (quiet_cycles == QUIET_LIMIT) begin
			$display("end of test: mismatches");
			$finish;
		end
	end

	initial begin : rx_stall
		int on_n;
		int off_n;
		int r;
		wait (arst_n);
		@(posedge clk);
		forever begin
			r = $urandom_range(0, 99);
			if (r < 70) on_n = $urandom_range(1, 8);
			else if (r < 90) on_n = $urandom_range(9, 40);
			else on_n = $urandom_range(60, 200);
			r = $urandom_range(0, 99);
			if (r < 60) off_n = 0;
			else if (r < 90) off_n = $urandom_range(1, 4);
			else off_n = $urandom_range(10, 60);
			m_axis_tready <= 1'b1;
			repeat (on_n) @(posedge clk);
			if (off_n != 0) begin
				m_axis_tready <= 1'b0;
				repeat (off_n) @(posedge clk);
			end
		end
	end

	initial begin : stim
		int   r;
		int   n;
		int   a;
		int   b;
		int   rand_sent;
		logic do_win;
		logic do_per;
		logic [CFG_DATA_W-1:0] win;
		logic [CFG_DATA_W-1:0] per;
		pat_t pat;
		logic lvl;

		std_rate = '{9600, 19200, 38400, 57600, 115200, 4800, 2400, 1200};
		cfg_window = WIN_DEFAULT;
		cfg_period = PER_DEFAULT;
		clear_window();

		//        wr    win    per    pattern     a    b    count typed first highs us
		plan[0]  = '{1'b0, 0,   0,     PAT_CONST,  0,   0,   256, 1'b1, 1'b0, 0,   1280};
		plan[1]  = '{1'b1, 16,  1,     PAT_CONST,  1,   0,   16,  1'b1, 1'b1, 15,  16};
		plan[2]  = '{1'b1, 512, 10000, PAT_CONST,  0,   0,   512, 1'b1, 1'b0, 0,   5120000};
		plan[3]  = '{1'b1, 15,  0,     PAT_CONST,  1,   0,   256, 1'b1, 1'b1, 255, 1280};
		plan[4]  = '{1'b1, 513, 10001, PAT_CONST,  0,   0,   256, 1'b1, 1'b0, 0,   1280};
		plan[5]  = '{1'b1, 16,  26,    PAT_SQUARE, 4,   4,   16,  1'b0, 1'b0, 0,   0};
		plan[6]  = '{1'b1, 32,  1,     PAT_SQUARE, 1,   1,   32,  1'b0, 1'b0, 0,   0};
		plan[7]  = '{1'b1, 512, 1,     PAT_SQUARE, 1,   511, 512, 1'b0, 1'b0, 0,   0};
		plan[8]  = '{1'b1, 64,  100,   PAT_SQUARE, 15,  17,  64,  1'b0, 1'b0, 0,   0};
		plan[9]  = '{1'b1, 64,  400,   PAT_SQUARE, 15,  17,  64,  1'b0, 1'b0, 0,   0};
		plan[10] = '{1'b1, 256, 5,     PAT_NOISE,  0,   0,   100, 1'b0, 1'b0, 0,   0};
		// shrink the window below the samples taken and change the period
		plan[11] = '{1'b1, 40,  7,     PAT_NOISE,  0,   0,   1,   1'b0, 1'b0, 0,   0};
		plan[12] = '{1'b1, 16,  1,     PAT_NOISE,  0,   0,   64,  1'b0, 1'b0, 0,   0};
		// more runs than the run record holds, then one long run
		plan[13] = '{1'b1, 512, 3,     PAT_TAIL,   300, 0,   512, 1'b0, 1'b0, 0,   0};
		plan[14] = '{1'b1, 16,  9,     PAT_SQUARE, 1,   2,   48,  1'b0, 1'b0, 0,   0};

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int k = 0; k < PLAN_ROWS; k++) begin
			if (plan[k].wr) begin
				settle();
				write_regs(1'b1, CFG_DATA_W'(plan[k].win), 1'b1, CFG_DATA_W'(plan[k].per));
			end
			if (plan[k].typed) begin
				typed_report = '0;
				typed_report.first_level  = plan[k].wfirst;
				typed_report.high_count   = CNT_W'(plan[k].whighs);
				typed_report.min_pulse_us = US_W'(plan[k].wus);
				typed_report.max_pulse_us = US_W'(plan[k].wus);
				typed_pending = 1'b1;
			end
			tx_quiet = (k % 3 == 0);
			gen_start(plan[k].pat, plan[k].a, plan[k].b, 1'b0);
			repeat (plan[k].count) begin
				next_level(lvl);
				send_level(lvl);
			end
			stop_tx();
		end

		rand_sent = 0;
		while (rand_sent < 1000 || reports_seen < 60) begin
			settle();

			do_win = ($urandom_range(0, 9) < 7);
			r = $urandom_range(0, 99);
			if (r < 55) win = CFG_DATA_W'($urandom_range(16, 40));
			else if (r < 65) win = CFG_DATA_W'(16);
			else if (r < 72) win = CFG_DATA_W'(512);
			else if (r < 80) win = CFG_DATA_W'($urandom_range(41, 512));
			else if (r < 90) win = ($urandom_range(0, 1) != 0) ?
				CFG_DATA_W'($urandom_range(0, 15)) : CFG_DATA_W'($urandom_range(513, 1023));
			else win = CFG_DATA_W'($urandom_range(0, 16383));

			do_per = ($urandom_range(0, 9) < 6);
			r = $urandom_range(0, 99);
			if (r < 30) per = CFG_DATA_W'($urandom_range(1, 30));
			else if (r < 45) begin
				case ($urandom_range(0, 7))
					0: per = CFG_DATA_W'(9);
					1: per = CFG_DATA_W'(17);
					2: per = CFG_DATA_W'(26);
					3: per = CFG_DATA_W'(52);
					4: per = CFG_DATA_W'(104);
					5: per = CFG_DATA_W'(208);
					6: per = CFG_DATA_W'(417);
					default: per = CFG_DATA_W'(833);
				endcase
			end
			else if (r < 60) per = CFG_DATA_W'($urandom_range(100, 700));
			else if (r < 68) per = CFG_DATA_W'(10000);
			else if (r < 78) per = CFG_DATA_W'($urandom_range(1000, 9999));
			else if (r < 88) per = ($urandom_range(0, 1) != 0) ?
				CFG_DATA_W'(0) : CFG_DATA_W'($urandom_range(10001, 16383));
			else per = CFG_DATA_W'($urandom_range(0, 16383));

			write_regs(do_win, win, do_per, per);

			r = $urandom_range(0, 99);
			a = 0;
			b = 0;
			if (r < 35) begin
				pat = PAT_SQUARE;
				if ($urandom_range(0, 4) == 0) begin
					a = $urandom_range(1, 300);
					b = $urandom_range(1, 300);
				end else begin
					a = $urandom_range(1, 20);
					b = $urandom_range(1, 20);
				end
			end else if (r < 60) begin
				pat = PAT_RUNS;
				a = $urandom_range(1, 60);
			end else if (r < 75) begin
				pat = PAT_NOISE;
			end else if (r < 85) begin
				pat = PAT_CONST;
				a = $urandom_range(0, 1);
			end else begin
				pat = PAT_TAIL;
				a = $urandom_range(0, cfg_window);
			end
			gen_start(pat, a, b, 1'($urandom_range(0, 1)));

			n = (cfg_window > 100) ? int'(cfg_window) : int'(cfg_window) * $urandom_range(1, 3);
			if ($urandom_range(0, 3) == 0) n += $urandom_range(0, cfg_window - 1);
			tx_quiet = ($urandom_range(0, 4) == 0);
			repeat (n) begin
				next_level(lvl);
				send_level(lvl);
			end
			rand_sent += n;
			stop_tx();
		end

		while (reports_due.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (reports_due.size() != 0) note_mismatch("reports missing", 0, reports_due.size());
		if (mismatches == 0) begin
			$display("end of test: clean");
		end else begin
			$display("end of test: mismatches");
		end
		$finish;
	end

endmodule

/* files.f */
src/lac_pkg.sv
src/lac_stats.sv
src/lac_arith.sv
src/lac_seq.sv
src/line_activity_classifier_top.sv
src/lac_checker.sv
tb/sv/line_activity_classifier_top_tb.sv
